// File: hdl/dwra_pkg.sv
// Package for the DNA wavelet rank and access block: sizes, codes and the byte map.
// Used by every module of the block; depends on nothing.
package dwra_pkg;

    localparam int MaxLen    = 65536;
    localparam int BlockSize = 64;
    localparam int NSym      = 6;
    localparam int AddrW     = $clog2(MaxLen);
    localparam int CntW      = AddrW + 1;
    localparam int BlkW      = $clog2(BlockSize);
    localparam int NBlocks   = MaxLen / BlockSize;
    localparam int DirW      = $clog2(NBlocks * NSym);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADCHAR  = 3'd1;
    localparam logic [2:0] ST_NOTBUILT = 3'd2;
    localparam logic [2:0] ST_REFUSED  = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    localparam logic [2:0] NoCode = 3'd7;

    // Work handed from the front to the back through the queue.
    typedef struct packed {
        logic       op;
        logic [2:0] code;
        logic       last;
        logic [CntW-1:0] qidx;
        logic [2:0] qsym;
    } dwra_cmd_t;

    // Maps a sequence byte (NACGT in either case, '$' or raw 0 to 5) to a symbol code, else NoCode.
    function automatic logic [2:0] map_byte(input logic [7:0] b);
        logic [2:0] c;
        begin
            case (b)
                8'd0, 8'h24:        c = 3'd0;
                8'd1, 8'h4E, 8'h6E: c = 3'd1;
                8'd2, 8'h41, 8'h61: c = 3'd2;
                8'd3, 8'h43, 8'h63: c = 3'd3;
                8'd4, 8'h47, 8'h67: c = 3'd4;
                8'd5, 8'h54, 8'h74: c = 3'd5;
                default:            c = NoCode;
            endcase
            return c;
        end
    endfunction

endpackage

// File: hdl/dwra_front.sv
// Front end: takes items, maps load bytes to codes and pushes commands to a two-entry queue.
// Depends on dwra_pkg.
module dwra_front
    import dwra_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            op,
    input  logic [7:0]      load_byte,
    input  logic            load_last,
    input  logic [16:0]     query_index,
    input  logic [2:0]      query_symbol,
    input  logic            pop,
    output logic            cmd_valid,
    output dwra_cmd_t       cmd
);

    dwra_cmd_t q_reg [2];
    logic      rd_ptr_reg, rd_ptr_next;
    logic      wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      push;

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue pointers and fill level.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Classified item goes into the queue slot.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].op   <= op;
            q_reg[wr_ptr_reg].code <= map_byte(load_byte);
            q_reg[wr_ptr_reg].last <= load_last;
            q_reg[wr_ptr_reg].qidx <= query_index;
            q_reg[wr_ptr_reg].qsym <= query_symbol;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> cmd_valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue level out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue level not advanced on push");

endmodule

// File: hdl/dwra_back.sv
// Back end: symbol store, rank directory, totals, build sweep and query sequencer.
// Depends on dwra_pkg.
module dwra_back
    import dwra_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  dwra_cmd_t       cmd,
    output logic            pop,
    output logic            done,
    output logic [2:0]      status,
    output logic            access_valid,
    output logic [2:0]      symbol_at_index,
    output logic [16:0]     rank_count,
    output logic [16:0]     total_count,
    output logic [16:0]     sequence_length
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BUILD = 3'd1;
    localparam logic [2:0] S_QDIR  = 3'd2;
    localparam logic [2:0] S_QSCAN = 3'd3;
    localparam logic [2:0] S_QEND  = 3'd4;
    localparam logic [2:0] S_BREAD = 3'd5;

    logic [2:0] store_mem [MaxLen];
    logic [CntW-1:0] dir_mem [NBlocks*NSym];

    logic [2:0]      state_reg, state_next;
    logic [CntW-1:0] tot_reg [NSym];
    logic [CntW-1:0] run_reg [NSym];
    logic [CntW-1:0] len_reg;
    logic            built_reg;
    logic [CntW-1:0] ptr_reg, ptr_next;
    logic [2:0]      sidx_reg;
    dwra_cmd_t       cur_reg;
    logic [CntW-1:0] rank_reg;
    logic [2:0]      sym_rd_reg;
    logic [CntW-1:0] dir_rd_reg;
    logic            st_we, dir_we;
    logic [AddrW-1:0] st_waddr, st_raddr;
    logic [DirW-1:0] dir_waddr, dir_raddr;
    logic [CntW-1:0] dir_wdata;
    logic            fin;
    logic            load_ok;
    logic            long_q;
    logic [2:0]      acc_status;
    logic [CntW-1:0] acc_rank;
    logic [CntW-1:0] acc_tot;

    assign sequence_length = len_reg;

    // Store and directory are plain memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= cmd.code;
        sym_rd_reg <= store_mem[st_raddr];
        if (dir_we)
            dir_mem[dir_waddr] <= dir_wdata;
        dir_rd_reg <= dir_mem[dir_raddr];
    end

    // The directory is read at the edge that takes a query, so the address comes from the queue.
    assign dir_wdata = run_reg[sidx_reg];
    assign dir_waddr = DirW'(ptr_reg[AddrW-1:BlkW]) * DirW'(NSym) + DirW'(sidx_reg);
    assign dir_raddr = DirW'(cmd.qidx[AddrW-1:BlkW]) * DirW'(NSym) + DirW'(cmd.qsym);
    assign st_waddr  = len_reg[AddrW-1:0];
    assign st_raddr  = ptr_reg[AddrW-1:0];

    // Classification of the item at the head of the queue.
    always_comb
    begin
        acc_status = ST_OK;
        acc_rank   = '0;
        acc_tot    = '0;
        load_ok    = 1'b0;
        long_q     = 1'b0;
        if (!cmd.op)
        begin
            if (built_reg || len_reg == CntW'(MaxLen))
                acc_status = ST_REFUSED;
            else if (cmd.code == NoCode)
                acc_status = ST_BADCHAR;
            else
                load_ok = 1'b1;
        end
        else if (!built_reg)
            acc_status = ST_NOTBUILT;
        else
        begin
            if (cmd.qsym < 3'(NSym))
                acc_tot = tot_reg[cmd.qsym];
            if (cmd.qidx > len_reg)
                acc_status = ST_RANGE;
            else if (cmd.qidx == len_reg)
                acc_rank = acc_tot;
            else
                long_q = 1'b1;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        pop        = 1'b0;
        st_we      = 1'b0;
        dir_we     = 1'b0;
        fin        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                pop   = cmd_valid;
                st_we = cmd_valid && load_ok;
            end
            S_BUILD:
            begin
                // Blocks boundary: write six directory words, then count one symbol.
                if (ptr_reg >= len_reg)
                    state_next = S_IDLE;
                else if (ptr_reg[BlkW-1:0] == '0 && sidx_reg != 3'd6)
                    dir_we = 1'b1;
                else
                    state_next = S_BREAD;
            end
            S_BREAD:
            begin
                state_next = S_BUILD;
                ptr_next   = ptr_reg + 1'b1;
            end
            S_QDIR:
            begin
                state_next = S_QSCAN;
            end
            S_QSCAN:
            begin
                if (ptr_reg >= cur_reg.qidx)
                    state_next = S_QEND;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_QEND:
            begin
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, totals and the result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            built_reg       <= 1'b0;
            done            <= 1'b0;
            status          <= ST_OK;
            access_valid    <= 1'b0;
            symbol_at_index <= 3'd0;
            rank_count      <= '0;
            total_count     <= '0;
            for (int s = 0; s < NSym; s++)
                tot_reg[s] <= '0;
        end
        else if (state_reg == S_IDLE && cmd_valid)
        begin
            // A query inside the sequence holds its result until the scan finishes.
            done            <= !long_q;
            status          <= acc_status;
            access_valid    <= 1'b0;
            symbol_at_index <= 3'd0;
            rank_count      <= acc_rank;
            total_count     <= acc_tot;
            if (load_ok)
            begin
                len_reg           <= len_reg + 1'b1;
                tot_reg[cmd.code] <= tot_reg[cmd.code] + 1'b1;
            end
            if (!cmd.op && !built_reg && cmd.last)
            begin
                built_reg <= 1'b1;
                state_reg <= S_BUILD;
            end
            else if (long_q)
                state_reg <= S_QDIR;
        end
        else
        begin
            state_reg <= state_next;
            done      <= fin;
            if (fin)
            begin
                status          <= ST_OK;
                access_valid    <= 1'b1;
                symbol_at_index <= sym_rd_reg;
                rank_count      <= (cur_reg.qsym < 3'(NSym)) ? rank_reg : '0;
            end
        end
    end

    // Datapath registers for the build sweep and the block scan.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            cur_reg  <= cmd;
            sidx_reg <= 3'd0;
            if (cmd_valid && !cmd.op)
            begin
                ptr_reg <= '0;
                for (int s = 0; s < NSym; s++)
                    run_reg[s] <= '0;
            end
            else
                ptr_reg <= {cmd.qidx[CntW-1:BlkW], BlkW'(0)};
        end
        else if (state_reg == S_BUILD)
        begin
            if (dir_we)
                sidx_reg <= sidx_reg + 1'b1;
        end
        else if (state_reg == S_BREAD)
        begin
            // The symbol under the pointer has been read; count it before the next boundary.
            sidx_reg <= 3'd0;
            ptr_reg  <= ptr_next;
            if (sym_rd_reg < 3'(NSym))
                run_reg[sym_rd_reg] <= run_reg[sym_rd_reg] + 1'b1;
        end
        else if (state_reg == S_QDIR)
        begin
            rank_reg <= dir_rd_reg;
        end
        else if (state_reg == S_QSCAN)
        begin
            // Read data lags the pointer by one, so this counts the symbol before it.
            ptr_reg <= ptr_next;
            if (ptr_reg > {cur_reg.qidx[CntW-1:BlkW], BlkW'(0)}
                && ptr_reg <= cur_reg.qidx && sym_rd_reg == cur_reg.qsym)
                rank_reg <= rank_reg + 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> state_reg == S_IDLE)
        else $error("command taken while back end busy");
    assert property (@(posedge clk) disable iff (!rst_n) fin |=> done)
        else $error("query finished without result");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BUILD |-> built_reg)
        else $error("build sweep without built flag");

endmodule

// File: hdl/dna_wavelet_rank_access.sv
// Top level of the DNA rank and access index: front end, command queue and back end.
// Depends on dwra_pkg, dwra_front and dwra_back.
//
//  channel  | handshake       | fields
//  ---------+-----------------+----------------------------------------------------
//  input    | start / busy    | op, load_byte, load_last, query_index, query_symbol
//  result   | done (strobe)   | status, access_valid, symbol_at_index, rank_count,
//           |                 | total_count, sequence_length
//
// With the back end idle, a load or short query raises done in the cycle after the item is
// taken; a query inside the sequence raises it once the one-read-a-cycle scan of the store's
// block reaches the queried index.
// The last load starts the build sweep, writing six directory words per block boundary.
// A two-entry queue lets items be taken while the back end works; busy is high when full.
// Reset is asynchronous and clears control state and the symbol totals; results cannot stall.
module dna_wavelet_rank_access
    import dwra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [7:0]  load_byte,
    input  logic        load_last,
    input  logic [16:0] query_index,
    input  logic [2:0]  query_symbol,
    output logic        done,
    output logic [2:0]  status,
    output logic        access_valid,
    output logic [2:0]  symbol_at_index,
    output logic [16:0] rank_count,
    output logic [16:0] total_count,
    output logic [16:0] sequence_length
);

    logic      pop;
    logic      cmd_valid;
    dwra_cmd_t cmd;

    // Front end and queue.
    dwra_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .load_byte(load_byte), .load_last(load_last), .query_index(query_index),
        .query_symbol(query_symbol), .pop(pop), .cmd_valid(cmd_valid), .cmd(cmd)
    );

    // Back end.
    dwra_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .pop(pop),
        .done(done), .status(status), .access_valid(access_valid),
        .symbol_at_index(symbol_at_index), .rank_count(rank_count),
        .total_count(total_count), .sequence_length(sequence_length)
    );

endmodule
